@@ rtl/core/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the checker file
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the cycle after the antecedent
`define AHF_ASSERT_NEXT(lbl, clk, dis, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
      else $error(msg);

// Consequent must hold in the same cycle as the antecedent
`define AHF_ASSERT_SAME(lbl, clk, dis, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
      else $error(msg);

`endif

@@ rtl/core/ahfs_pkg.sv @@
// ----------------------------------------------------------------------------
// ahfs_pkg
// Types, constants and operation codes of the auto-hide fade/slide engine.
// ----------------------------------------------------------------------------
package ahfs_pkg;

   // Fixed-point and field widths
   localparam int FRAC_BITS  = 8;
   localparam int NOW_W      = 20;
   localparam int VEL_W      = 24;
   localparam int DT_W       = 17;
   localparam int MUL_A_W    = 28;
   localparam int PROD_W     = 45;
   localparam int QUO_W      = 26;
   localparam int REM_W      = 20;
   localparam int DIV_CNT_W  = 2;

   // Division by one million: drop six bits, then divide by 15625 through
   // a reciprocal estimate, a back-multiply and a small correction
   localparam logic [DIV_CNT_W-1:0] DIV_PH_EST = 2'd0;
   localparam logic [DIV_CNT_W-1:0] DIV_PH_REM = 2'd1;
   localparam logic [DIV_CNT_W-1:0] DIV_PH_FIX = 2'd2;
   localparam logic [25:0]          RECIP_M    = 26'd35184372;
   localparam logic [13:0]          DIV_ODD    = 14'd15625;

   localparam logic [19:0]      DT_CAP_US    = 20'd100000;
   localparam logic [DT_W-1:0]  DT_SUB_US    = 17'd50000;
   localparam logic [9:0]       MS_TO_US     = 10'd1000;
   localparam logic [VEL_W-1:0] VEL_MAX      = 24'hFFFFFF;
   localparam logic [NOW_W-1:0] HALF_FX      = 20'd128;
   localparam logic [VEL_W-1:0] ONE_FX       = 24'd256;
   localparam logic [MUL_A_W-1:0] POS_MIN_FX   = 28'd12800;
   localparam logic [MUL_A_W-1:0] ALPHA_MIN_FX = 28'd2560;
   localparam logic [7:0]       ALPHA_FULL   = 8'd255;

   // Register indexes
   localparam logic [2:0] REG_HIDE_DELAY  = 3'd0;
   localparam logic [2:0] REG_MOVE_THR    = 3'd1;
   localparam logic [2:0] REG_HIDDEN_POS  = 3'd2;
   localparam logic [2:0] REG_POS_ACCEL   = 3'd3;
   localparam logic [2:0] REG_POS_SPEED   = 3'd4;
   localparam logic [2:0] REG_ALPHA_ACCEL = 3'd5;
   localparam logic [2:0] REG_ALPHA_SPEED = 3'd6;

   // Datapath operations
   localparam logic [3:0] OP_NONE     = 4'd0;
   localparam logic [3:0] OP_LOAD     = 4'd1;
   localparam logic [3:0] OP_UPDATE   = 4'd2;
   localparam logic [3:0] OP_DT       = 4'd3;
   localparam logic [3:0] OP_EVAL     = 4'd4;
   localparam logic [3:0] OP_MUL_ACC  = 4'd5;
   localparam logic [3:0] OP_MUL_VEL  = 4'd6;
   localparam logic [3:0] OP_MUL_DIFF = 4'd7;
   localparam logic [3:0] OP_MUL_MAG  = 4'd8;
   localparam logic [3:0] OP_DIV_STEP = 4'd9;
   localparam logic [3:0] OP_VEL_ADD  = 4'd10;
   localparam logic [3:0] OP_APPLY    = 4'd11;
   localparam logic [3:0] OP_FINISH   = 4'd12;

   // Channels
   localparam logic CH_POS   = 1'b0;
   localparam logic CH_ALPHA = 1'b1;

   typedef struct packed {
      logic signed [15:0] pointer_x;
      logic signed [15:0] pointer_y;
      logic               on_region;
      logic [19:0]        elapsed_us;
   } req_data_type;

   typedef struct packed {
      logic [11:0] position;
      logic [7:0]  alpha;
      logic        position_moved;
      logic        alpha_moved;
      logic        is_hidden;
      logic        settled;
   } rsp_data_type;

   typedef struct packed {
      logic [15:0] idle_limit_ms;
      logic [7:0]  move_threshold;
      logic [11:0] hidden_position;
      logic [15:0] pos_accel_out;
      logic [15:0] pos_speed_in;
      logic [15:0] alpha_accel_out;
      logic [15:0] alpha_speed_in;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      idle_limit_ms:   16'd5000,
      move_threshold:  8'd2,
      hidden_position: 12'd1080,
      pos_accel_out:   16'd0,
      pos_speed_in:    16'd0,
      alpha_accel_out: 16'd32,
      alpha_speed_in:  16'd4096
   };

   typedef struct packed {
      logic [3:0] op;
      logic       ch;
   } cmd_type;

   typedef struct packed {
      logic active;
      logic accel_br;
      logic div_last;
      logic out_free;
   } sts_type;

endpackage

@@ rtl/core/ahfs_csr.sv @@
// ----------------------------------------------------------------------------
// ahfs_csr
// Configuration register file behind the APB-style port.
// ----------------------------------------------------------------------------
module ahfs_csr import ahfs_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready,
   output cfg_type     cfg
);

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic [2:0] idx;
   logic       wr_en;

   assign idx        = csr_paddr[4:2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   // Decode the write transfer
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (idx)
            REG_HIDE_DELAY:  cfg_in.idle_limit_ms   = csr_pwdata[15:0];
            REG_MOVE_THR:    cfg_in.move_threshold  = csr_pwdata[7:0];
            REG_HIDDEN_POS:  cfg_in.hidden_position = csr_pwdata[11:0];
            REG_POS_ACCEL:   cfg_in.pos_accel_out   = csr_pwdata[15:0];
            REG_POS_SPEED:   cfg_in.pos_speed_in    = csr_pwdata[15:0];
            REG_ALPHA_ACCEL: cfg_in.alpha_accel_out = csr_pwdata[15:0];
            REG_ALPHA_SPEED: cfg_in.alpha_speed_in  = csr_pwdata[15:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read back
   always_comb begin
      case (idx)
         REG_HIDE_DELAY:  csr_prdata = {16'd0, cfg_ff.idle_limit_ms};
         REG_MOVE_THR:    csr_prdata = {24'd0, cfg_ff.move_threshold};
         REG_HIDDEN_POS:  csr_prdata = {20'd0, cfg_ff.hidden_position};
         REG_POS_ACCEL:   csr_prdata = {16'd0, cfg_ff.pos_accel_out};
         REG_POS_SPEED:   csr_prdata = {16'd0, cfg_ff.pos_speed_in};
         REG_ALPHA_ACCEL: csr_prdata = {16'd0, cfg_ff.alpha_accel_out};
         REG_ALPHA_SPEED: csr_prdata = {16'd0, cfg_ff.alpha_speed_in};
         default:         csr_prdata = 32'd0;
      endcase
   end

endmodule

@@ rtl/core/ahfs_ctrl.sv @@
// ----------------------------------------------------------------------------
// ahfs_ctrl
// Sequencer: walks one tick through update, time step and both channels.
// ----------------------------------------------------------------------------
module ahfs_ctrl import ahfs_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  sts_type sts,
   output cmd_type cmd
);

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_UPD      = 4'd1;
   localparam logic [3:0] S_DT       = 4'd2;
   localparam logic [3:0] S_EVAL     = 4'd3;
   localparam logic [3:0] S_MUL_ACC  = 4'd4;
   localparam logic [3:0] S_DIV_A    = 4'd5;
   localparam logic [3:0] S_VADD     = 4'd6;
   localparam logic [3:0] S_MUL_VEL  = 4'd7;
   localparam logic [3:0] S_MUL_DIFF = 4'd8;
   localparam logic [3:0] S_MUL_MAG  = 4'd9;
   localparam logic [3:0] S_DIV_B    = 4'd10;
   localparam logic [3:0] S_APPLY    = 4'd11;
   localparam logic [3:0] S_FIN      = 4'd12;

   logic [3:0] state_ff, state_in;
   logic       ch_ff, ch_in;
   logic [3:0] op;
   logic [3:0] after_chan;
   logic       ch_after;

   assign req_ready = (state_ff == S_IDLE);
   assign cmd.op    = op;
   assign cmd.ch    = ch_ff;

   // Move on to alpha after position, else finish
   assign after_chan = (ch_ff == CH_POS) ? S_EVAL : S_FIN;
   assign ch_after   = (ch_ff == CH_POS) ? CH_ALPHA : ch_ff;

   always_comb begin
      state_in = state_ff;
      ch_in    = ch_ff;
      op       = OP_NONE;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op       = OP_LOAD;
               state_in = S_UPD;
            end
         end
         S_UPD: begin
            op       = OP_UPDATE;
            state_in = S_DT;
         end
         S_DT: begin
            op       = OP_DT;
            ch_in    = CH_POS;
            state_in = S_EVAL;
         end
         S_EVAL: begin
            op = OP_EVAL;
            if (!sts.active) begin
               state_in = after_chan;
               ch_in    = ch_after;
            end else if (sts.accel_br) begin
               state_in = S_MUL_ACC;
            end else begin
               state_in = S_MUL_DIFF;
            end
         end
         S_MUL_ACC: begin
            op       = OP_MUL_ACC;
            state_in = S_DIV_A;
         end
         S_DIV_A: begin
            op = OP_DIV_STEP;
            if (sts.div_last) state_in = S_VADD;
         end
         S_VADD: begin
            op       = OP_VEL_ADD;
            state_in = S_MUL_VEL;
         end
         S_MUL_VEL: begin
            op       = OP_MUL_VEL;
            state_in = S_DIV_B;
         end
         S_MUL_DIFF: begin
            op       = OP_MUL_DIFF;
            state_in = S_MUL_MAG;
         end
         S_MUL_MAG: begin
            op       = OP_MUL_MAG;
            state_in = S_DIV_B;
         end
         S_DIV_B: begin
            op = OP_DIV_STEP;
            if (sts.div_last) state_in = S_APPLY;
         end
         S_APPLY: begin
            op       = OP_APPLY;
            state_in = after_chan;
            ch_in    = ch_after;
         end
         S_FIN: begin
            if (sts.out_free) begin
               op       = OP_FINISH;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ch_ff    <= CH_POS;
      end else begin
         state_ff <= state_in;
         ch_ff    <= ch_in;
      end
   end

endmodule

@@ rtl/core/ahfs_dp.sv @@
// ----------------------------------------------------------------------------
// ahfs_dp
// Datapath: tick state, shared multiplier, reciprocal divider by one million,
// channel stepping and the result register.
// ----------------------------------------------------------------------------
module ahfs_dp import ahfs_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  cmd_type      cmd,
   input  req_data_type req_data,
   input  cfg_type      cfg,
   input  logic         rsp_ready,
   output sts_type      sts,
   output logic         rsp_valid,
   output rsp_data_type rsp_data
);

   req_data_type         in_ff, in_in;
   logic [15:0]          prev_x_ff, prev_x_in, prev_y_ff, prev_y_in;
   logic [31:0]          idle_ff, idle_in;
   logic                 hidden_ff, hidden_in;
   logic [NOW_W-1:0]     pos_now_ff, pos_now_in;
   logic [11:0]          pos_goal_ff, pos_goal_in;
   logic [VEL_W-1:0]     pos_vel_ff, pos_vel_in;
   logic [15:0]          alpha_now_ff, alpha_now_in;
   logic [7:0]           alpha_goal_ff, alpha_goal_in;
   logic [VEL_W-1:0]     alpha_vel_ff, alpha_vel_in;
   logic [DT_W-1:0]      dt_ff, dt_in;
   logic                 accel_br_ff, accel_br_in;
   logic                 pm_ff, pm_in, am_ff, am_in;
   logic [MUL_A_W-1:0]   mag_ff, mag_in;
   logic [PROD_W-1:0]    num_ff, num_in;
   logic [REM_W-1:0]     rem_ff, rem_in;
   logic [QUO_W-1:0]     dq_ff, dq_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_data_type         rsp_ff, rsp_in;

   // Channel view
   logic [NOW_W-1:0]   cur_now, cur_goal, diff_up, diff_dn, abs_diff, room;
   logic [VEL_W-1:0]   cur_vel;
   logic [15:0]        cur_accel, cur_speed;
   logic [MUL_A_W-1:0] cur_min;
   logic               goal_gt, goal_lt, active, accel_br, dir_up, over;
   logic [NOW_W-1:0]   now_step, now_new;
   logic [QUO_W-1:0]   vsum;
   logic [VEL_W-1:0]   vel_new;

   // Multiplier and divider
   logic [MUL_A_W-1:0] mul_a, mag_raw;
   logic [DT_W-1:0]    mul_b;
   logic [PROD_W-1:0]  product;
   logic [26:0]        div_hi;
   logic [52:0]        est_prod;
   logic [39:0]        back_prod;
   logic [39:0]        resid;
   logic [1:0]         fix;

   // Tick update
   logic [16:0] dx, dy, adx, ady;
   logic        moving;
   logic [32:0] idle_sum;
   logic [31:0] idle_sat;
   logic [25:0] hide_lim;
   logic        rest_pos, rest_alpha;

   function automatic logic at_rest(input logic [NOW_W-1:0] now,
                                    input logic [NOW_W-1:0] goal,
                                    input logic [VEL_W-1:0] vel);
      logic [NOW_W-1:0] d;
      d = (goal > now) ? (goal - now) : (now - goal);
      return (d < HALF_FX) && (vel < ONE_FX);
   endfunction

   // Select the channel being stepped
   assign cur_now   = (cmd.ch == CH_ALPHA) ? {4'd0, alpha_now_ff} : pos_now_ff;
   assign cur_goal  = (cmd.ch == CH_ALPHA) ? {4'd0, alpha_goal_ff, 8'd0}
                                           : {pos_goal_ff, 8'd0};
   assign cur_vel   = (cmd.ch == CH_ALPHA) ? alpha_vel_ff : pos_vel_ff;
   assign cur_accel = (cmd.ch == CH_ALPHA) ? cfg.alpha_accel_out : cfg.pos_accel_out;
   assign cur_speed = (cmd.ch == CH_ALPHA) ? cfg.alpha_speed_in : cfg.pos_speed_in;
   assign cur_min   = (cmd.ch == CH_ALPHA) ? ALPHA_MIN_FX : POS_MIN_FX;

   assign goal_gt  = cur_goal > cur_now;
   assign goal_lt  = cur_goal < cur_now;
   assign diff_up  = cur_goal - cur_now;
   assign diff_dn  = cur_now - cur_goal;
   assign abs_diff = goal_gt ? diff_up : diff_dn;
   assign active   = (abs_diff > HALF_FX) || (cur_vel > ONE_FX);
   // Position accelerates upward, alpha accelerates downward
   assign accel_br = (cmd.ch == CH_ALPHA) ? goal_lt : goal_gt;
   assign dir_up   = (cmd.ch == CH_ALPHA) ? !accel_br_ff : accel_br_ff;

   // Step toward the goal, stop at it
   assign room     = dir_up ? diff_up : diff_dn;
   assign over     = dq_ff > {6'd0, room};
   assign now_step = dir_up ? (cur_now + dq_ff[NOW_W-1:0]) : (cur_now - dq_ff[NOW_W-1:0]);
   assign now_new  = over ? cur_goal : now_step;

   // Saturating velocity add
   assign vsum    = {2'd0, cur_vel} + dq_ff;
   assign vel_new = (vsum > {2'd0, VEL_MAX}) ? VEL_MAX : vsum[VEL_W-1:0];

   // Shared multiplier operands
   always_comb begin
      case (cmd.op)
         OP_MUL_ACC: begin
            mul_a = {4'd0, cur_accel, 8'd0};
            mul_b = dt_ff;
         end
         OP_MUL_VEL: begin
            mul_a = {4'd0, cur_vel};
            mul_b = dt_ff;
         end
         OP_MUL_DIFF: begin
            mul_a = {8'd0, (cmd.ch == CH_ALPHA) ? diff_up : diff_dn};
            mul_b = {1'b0, cur_speed};
         end
         default: begin
            mul_a = mag_ff;
            mul_b = dt_ff;
         end
      endcase
   end

   assign product = PROD_W'(mul_a) * PROD_W'(mul_b);
   assign mag_raw = product[MUL_A_W+FRAC_BITS-1:FRAC_BITS];

   // Divide by one million: estimate from the top bits, then correct
   assign div_hi    = num_ff[PROD_W-1:PROD_W-27];
   assign est_prod  = 53'(div_hi) * 53'(RECIP_M);
   assign back_prod = 40'(dq_ff) * 40'(DIV_ODD);
   assign resid     = {1'b0, num_ff[PROD_W-1:6]} - back_prod;
   assign fix       = (rem_ff >= {5'd0, DIV_ODD, 1'b0}) ? 2'd2 :
                      (rem_ff >= {6'd0, DIV_ODD})       ? 2'd1 : 2'd0;

   // Pointer movement and idle time
   assign dx       = {in_ff.pointer_x[15], in_ff.pointer_x} - {prev_x_ff[15], prev_x_ff};
   assign dy       = {in_ff.pointer_y[15], in_ff.pointer_y} - {prev_y_ff[15], prev_y_ff};
   assign adx      = dx[16] ? (~dx + 17'd1) : dx;
   assign ady      = dy[16] ? (~dy + 17'd1) : dy;
   assign moving   = (adx > {9'd0, cfg.move_threshold}) || (ady > {9'd0, cfg.move_threshold});
   assign idle_sum = {1'b0, idle_ff} + {13'd0, in_ff.elapsed_us};
   assign idle_sat = idle_sum[32] ? 32'hFFFFFFFF : idle_sum[31:0];
   assign hide_lim = 26'(cfg.idle_limit_ms) * 26'(MS_TO_US);

   assign rest_pos   = at_rest(pos_now_ff, {pos_goal_ff, 8'd0}, pos_vel_ff);
   assign rest_alpha = at_rest({4'd0, alpha_now_ff}, {4'd0, alpha_goal_ff, 8'd0},
                               alpha_vel_ff);

   assign sts.active   = active;
   assign sts.accel_br = accel_br;
   assign sts.div_last = (cnt_ff == DIV_PH_FIX);
   assign sts.out_free = !rsp_valid_ff || rsp_ready;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Next-state decode per operation
   always_comb begin
      in_in         = in_ff;
      prev_x_in     = prev_x_ff;
      prev_y_in     = prev_y_ff;
      idle_in       = idle_ff;
      hidden_in     = hidden_ff;
      pos_now_in    = pos_now_ff;
      pos_goal_in   = pos_goal_ff;
      pos_vel_in    = pos_vel_ff;
      alpha_now_in  = alpha_now_ff;
      alpha_goal_in = alpha_goal_ff;
      alpha_vel_in  = alpha_vel_ff;
      dt_in         = dt_ff;
      accel_br_in   = accel_br_ff;
      pm_in         = pm_ff;
      am_in         = am_ff;
      mag_in        = mag_ff;
      num_in        = num_ff;
      rem_in        = rem_ff;
      dq_in         = dq_ff;
      cnt_in        = cnt_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_in        = rsp_ff;
      case (cmd.op)
         OP_LOAD: begin
            in_in = req_data;
         end
         OP_UPDATE: begin
            idle_in = idle_sat;
            if (moving && in_ff.on_region) begin
               idle_in       = 32'd0;
               pos_goal_in   = 12'd0;
               alpha_goal_in = ALPHA_FULL;
               hidden_in     = 1'b0;
            end else if (!moving && !hidden_ff && (idle_sat > {6'd0, hide_lim})) begin
               pos_goal_in   = cfg.hidden_position;
               alpha_goal_in = 8'd0;
               hidden_in     = 1'b1;
               pos_vel_in    = '0;
               alpha_vel_in  = '0;
            end
            prev_x_in = in_ff.pointer_x;
            prev_y_in = in_ff.pointer_y;
         end
         OP_DT: begin
            if (rest_pos && rest_alpha) begin
               dt_in = '0;
            end else if (in_ff.elapsed_us > DT_CAP_US) begin
               dt_in = DT_SUB_US;
            end else begin
               dt_in = in_ff.elapsed_us[DT_W-1:0];
            end
         end
         OP_EVAL: begin
            accel_br_in = accel_br;
            if (cmd.ch == CH_ALPHA) begin
               am_in = active;
               if (!active) alpha_now_in = cur_goal[15:0];
            end else begin
               pm_in = active;
               if (!active) pos_now_in = cur_goal;
            end
         end
         OP_MUL_ACC, OP_MUL_VEL, OP_MUL_MAG: begin
            num_in = product;
            cnt_in = DIV_PH_EST;
         end
         OP_MUL_DIFF: begin
            mag_in = (mag_raw < cur_min) ? cur_min : mag_raw;
         end
         OP_DIV_STEP: begin
            case (cnt_ff)
               DIV_PH_EST: dq_in  = est_prod[52:27];
               DIV_PH_REM: rem_in = resid[REM_W-1:0];
               default:    dq_in  = dq_ff + {24'd0, fix};
            endcase
            cnt_in = cnt_ff + DIV_CNT_W'(1);
         end
         OP_VEL_ADD: begin
            if (cmd.ch == CH_ALPHA) alpha_vel_in = vel_new;
            else                    pos_vel_in   = vel_new;
         end
         OP_APPLY: begin
            if (cmd.ch == CH_ALPHA) begin
               alpha_now_in = now_new[15:0];
               if (over && accel_br_ff) alpha_vel_in = '0;
            end else begin
               pos_now_in = now_new;
               if (over && accel_br_ff) pos_vel_in = '0;
            end
         end
         OP_FINISH: begin
            rsp_valid_in          = 1'b1;
            rsp_in.position       = pos_now_ff[NOW_W-1:FRAC_BITS];
            rsp_in.alpha          = alpha_now_ff[15:FRAC_BITS];
            rsp_in.position_moved = pm_ff;
            rsp_in.alpha_moved    = am_ff;
            rsp_in.is_hidden      = hidden_ff;
            rsp_in.settled        = rest_pos && rest_alpha;
         end
         default: begin
            in_in = in_ff;
         end
      endcase
   end

   // Architectural state and handshake
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_x_ff     <= '0;
         prev_y_ff     <= '0;
         idle_ff       <= '0;
         hidden_ff     <= 1'b0;
         pos_now_ff    <= '0;
         pos_goal_ff   <= '0;
         pos_vel_ff    <= '0;
         alpha_now_ff  <= {ALPHA_FULL, 8'd0};
         alpha_goal_ff <= ALPHA_FULL;
         alpha_vel_ff  <= '0;
         cnt_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         prev_x_ff     <= prev_x_in;
         prev_y_ff     <= prev_y_in;
         idle_ff       <= idle_in;
         hidden_ff     <= hidden_in;
         pos_now_ff    <= pos_now_in;
         pos_goal_ff   <= pos_goal_in;
         pos_vel_ff    <= pos_vel_in;
         alpha_now_ff  <= alpha_now_in;
         alpha_goal_ff <= alpha_goal_in;
         alpha_vel_ff  <= alpha_vel_in;
         cnt_ff        <= cnt_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Working payload, no reset
   always_ff @(posedge clock) begin
      in_ff       <= in_in;
      dt_ff       <= dt_in;
      accel_br_ff <= accel_br_in;
      pm_ff       <= pm_in;
      am_ff       <= am_in;
      mag_ff      <= mag_in;
      num_ff      <= num_in;
      rem_ff      <= rem_in;
      dq_ff       <= dq_in;
      rsp_ff      <= rsp_in;
   end

endmodule

@@ rtl/core/auto_hide_fade_slide_engine.sv @@
// ----------------------------------------------------------------------------
// auto_hide_fade_slide_engine
// Auto-hide overlay engine: pointer activity shows, idle time hides, and the
// position and alpha channels slide and fade toward their targets.
//
//   channel   direction  handshake                transfer
//   req_      in         req_valid / req_ready    one tick item
//   rsp_      out        rsp_valid / rsp_ready    one result item
//   csr_      in/out     psel/penable/pready      one register access
//
// One tick at a time. The result register loads once both channels are stepped:
// a channel at rest is only evaluated, an accelerating channel costs two
// multiply passes, an approaching one a gain multiply and one pass, each pass
// followed by a reciprocal division by one million in estimate, remainder and
// correction steps. A new tick is taken only back in idle; req_ready rises
// again while a result waits. Reset is synchronous; a stalled rsp_ready
// holds the next tick in its finishing state.
// ----------------------------------------------------------------------------
module auto_hide_fade_slide_engine import ahfs_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_data_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_data_type rsp_data,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [4:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);

   cfg_type cfg;
   cmd_type cmd;
   sts_type sts;

   ahfs_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   ahfs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   ahfs_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_data  (req_data),
      .cfg       (cfg),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

@@ rtl/core/ahfs_checker.sv @@
// ----------------------------------------------------------------------------
// ahfs_checker
// Port-level checks of the auto-hide engine, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ahfs_checker import ahfs_pkg::*; (
   input logic         clock,
   input logic         reset,
   input logic         req_valid,
   input logic         req_ready,
   input logic         rsp_valid,
   input logic         rsp_ready,
   input rsp_data_type rsp_data
);

   // Result holds while stalled
   `AHF_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "result changed while stalled")

   // Ready drops once a tick is taken, while the tick is worked on
   `AHF_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready, "ready stayed high after a transfer")

   // Reset leaves the block empty and ready
   `AHF_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid && req_ready, "block not empty after reset")

   // Hidden and settled means fully transparent
   `AHF_ASSERT_SAME(a_hidden_clear, clock, reset, rsp_valid && rsp_data.is_hidden && rsp_data.settled, rsp_data.alpha == 8'd0, "settled hidden overlay still visible")

endmodule

bind auto_hide_fade_slide_engine ahfs_checker u_ahfs_checker (.*);

@@ dv/auto_hide_fade_slide_engine_test.sv @@
// ----------------------------------------------------------------------------
// auto_hide_fade_slide_engine_test
// Self-checking bench for the auto-hide engine. A queue of tick items feeds a
// valid/ready driver. A built-in predictor tracks the show/hide state and the
// position and alpha channels and works out every result. A monitor compares
// each result transfer field by field with the oldest expected one. Registers
// are written over the APB port between phases while the engine is idle.
// ----------------------------------------------------------------------------
module auto_hide_fade_slide_engine_test;
   import ahfs_pkg::*;

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_ready;
   req_data_type req_data;
   logic         rsp_valid;
   logic         rsp_ready;
   rsp_data_type rsp_data;
   logic         csr_psel;
   logic         csr_penable;
   logic         csr_pwrite;
   logic [4:0]   csr_paddr;
   logic [31:0]  csr_pwdata;
   logic [31:0]  csr_prdata;
   logic         csr_pready;

   auto_hide_fade_slide_engine DUT (.*);

   // Predictor state and shadow registers
   cfg_type     shadow_cfg;
   logic [15:0] last_x, last_y;
   logic [31:0] idle_us;
   logic        hidden;
   longint      pos_fx, pos_tgt, pos_speed, alpha_fx, alpha_tgt, alpha_speed;

   req_data_type tick_queue[$];
   rsp_data_type expected_results[$];
   int           error_count;
   int           cycle_count;
   int           send_gap;
   int           recv_gap;
   bit           hold_sender;

   // Clock
   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("mismatch %s: got %0d expected %0d (cycle %0d)", what, got, want, cycle_count);
      error_count++;
   endtask

   function automatic bit channel_still(longint now_fx, longint tgt, longint spd);
      longint d;
      d = (tgt << 8) - now_fx;
      if (d < 0) d = -d;
      return d < 128 && spd < 256;
   endfunction

   function automatic longint add_speed(longint spd, longint accel, longint dt);
      longint v;
      v = spd + ((accel << 8) * dt) / 1000000;
      return v > 64'hFFFFFF ? 64'hFFFFFF : v;
   endfunction

   // Advance the predictor by one tick and return its result
   function automatic rsp_data_type predict_tick(req_data_type t);
      rsp_data_type r;
      longint dx, dy, dt, tgt, diff, mag, a, sum;
      bit moving, pm, am;
      sum = longint'(idle_us) + t.elapsed_us;
      idle_us = sum > 64'hFFFFFFFF ? 32'hFFFFFFFF : sum[31:0];
      dx = longint'(t.pointer_x) - longint'($signed(last_x));
      dy = longint'(t.pointer_y) - longint'($signed(last_y));
      if (dx < 0) dx = -dx;
      if (dy < 0) dy = -dy;
      moving = dx > shadow_cfg.move_threshold || dy > shadow_cfg.move_threshold;
      if (moving && t.on_region) begin
         idle_us = 0;
         pos_tgt = 0;
         alpha_tgt = 255;
         hidden = 1'b0;
      end else if (!moving) begin
         if (!hidden && longint'(idle_us) > longint'(shadow_cfg.idle_limit_ms) * 1000) begin
            pos_tgt = shadow_cfg.hidden_position;
            alpha_tgt = 0;
            hidden = 1'b1;
            pos_speed = 0;
            alpha_speed = 0;
         end
      end
      last_x = t.pointer_x;
      last_y = t.pointer_y;
      if (channel_still(pos_fx, pos_tgt, pos_speed) &&
          channel_still(alpha_fx, alpha_tgt, alpha_speed))
         dt = 0;
      else
         dt = t.elapsed_us > 100000 ? 50000 : t.elapsed_us;
      // Position channel: accelerate out, proportional approach back
      tgt = pos_tgt << 8;
      diff = tgt - pos_fx;
      pm = (diff > 128 || -diff > 128 || pos_speed > 256);
      if (!pm) begin
         pos_fx = tgt;
      end else if (tgt > pos_fx) begin
         pos_speed = add_speed(pos_speed, shadow_cfg.pos_accel_out, dt);
         pos_fx += (pos_speed * dt) / 1000000;
         if (pos_fx > tgt) begin
            pos_fx = tgt;
            pos_speed = 0;
         end
      end else begin
         mag = ((-diff) * shadow_cfg.pos_speed_in) >>> 8;
         if (mag < 12800) mag = 12800;
         pos_fx -= (mag * dt) / 1000000;
         if (pos_fx < tgt) pos_fx = tgt;
      end
      // Alpha channel: accelerate down, proportional approach up
      tgt = alpha_tgt << 8;
      diff = tgt - alpha_fx;
      am = (diff > 128 || -diff > 128 || alpha_speed > 256);
      if (!am) begin
         alpha_fx = tgt;
      end else if (tgt < alpha_fx) begin
         alpha_speed = add_speed(alpha_speed, shadow_cfg.alpha_accel_out, dt);
         alpha_fx -= (alpha_speed * dt) / 1000000;
         if (alpha_fx < tgt) begin
            alpha_fx = tgt;
            alpha_speed = 0;
         end
      end else begin
         mag = (diff * shadow_cfg.alpha_speed_in) >>> 8;
         if (mag < 2560) mag = 2560;
         alpha_fx += (mag * dt) / 1000000;
         if (alpha_fx > tgt) alpha_fx = tgt;
      end
      a = alpha_fx >>> 8;
      if (a < 0) a = 0;
      if (a > 255) a = 255;
      r.position = 12'(pos_fx >>> 8);
      r.alpha = 8'(a);
      r.position_moved = pm;
      r.alpha_moved = am;
      r.is_hidden = hidden;
      r.settled = channel_still(pos_fx, pos_tgt, pos_speed) &&
                  channel_still(alpha_fx, alpha_tgt, alpha_speed);
      return r;
   endfunction

   // Driver: take the next item after a random gap, predict on transfer
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (reset) begin
         req_valid <= 1'b0;
         send_gap <= $urandom_range(0, 16);
      end else if (req_valid && req_ready) begin
         expected_results.push_back(predict_tick(req_data));
         void'(tick_queue.pop_front());
         send_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
         if (send_gap == 0 && tick_queue.size() > 0 && !hold_sender) begin
            req_data <= tick_queue[0];
         end else begin
            req_valid <= 1'b0;
         end
      end else if (!req_valid) begin
         if (send_gap > 0) begin
            send_gap <= send_gap - 1;
         end else if (tick_queue.size() > 0 && !hold_sender) begin
            req_valid <= 1'b1;
            req_data <= tick_queue[0];
         end
      end
   end

   // Monitor: compare each result transfer and stall at random
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         recv_gap <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               report_mismatch("unexpected result", rsp_data, 0);
            end else begin
               if (rsp_data.position != expected_results[0].position)
                  report_mismatch("position", rsp_data.position,
                                  expected_results[0].position);
               if (rsp_data.alpha != expected_results[0].alpha)
                  report_mismatch("alpha", rsp_data.alpha, expected_results[0].alpha);
               if (rsp_data.position_moved != expected_results[0].position_moved)
                  report_mismatch("position_moved", rsp_data.position_moved,
                                  expected_results[0].position_moved);
               if (rsp_data.alpha_moved != expected_results[0].alpha_moved)
                  report_mismatch("alpha_moved", rsp_data.alpha_moved,
                                  expected_results[0].alpha_moved);
               if (rsp_data.is_hidden != expected_results[0].is_hidden)
                  report_mismatch("is_hidden", rsp_data.is_hidden,
                                  expected_results[0].is_hidden);
               if (rsp_data.settled != expected_results[0].settled)
                  report_mismatch("settled", rsp_data.settled, expected_results[0].settled);
               void'(expected_results.pop_front());
            end
         end
         if (recv_gap > 0) begin
            rsp_ready <= 1'b0;
            recv_gap <= recv_gap - 1;
         end else begin
            rsp_ready <= 1'b1;
            if (rsp_valid && rsp_ready)
               recv_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
         end
      end
   end

   // Timeout
   always @(posedge clock) begin
      if (cycle_count > 900000) begin
         $display("auto_hide_fade_slide_engine_test: errors");
         $finish;
      end
   end

   task automatic write_register(input logic [2:0] index, input logic [31:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {index, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (index)
         REG_HIDE_DELAY:  shadow_cfg.idle_limit_ms = value[15:0];
         REG_MOVE_THR:    shadow_cfg.move_threshold = value[7:0];
         REG_HIDDEN_POS:  shadow_cfg.hidden_position = value[11:0];
         REG_POS_ACCEL:   shadow_cfg.pos_accel_out = value[15:0];
         REG_POS_SPEED:   shadow_cfg.pos_speed_in = value[15:0];
         REG_ALPHA_ACCEL: shadow_cfg.alpha_accel_out = value[15:0];
         default:         shadow_cfg.alpha_speed_in = value[15:0];
      endcase
   endtask

   // Hold until every queued item is taken and every result has come
   task automatic drain();
      while (tick_queue.size() > 0 || expected_results.size() > 0 || req_valid)
         @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   function automatic req_data_type make_tick(int x, int y, bit onr, int el);
      req_data_type t;
      t.pointer_x = 16'(x);
      t.pointer_y = 16'(y);
      t.on_region = onr;
      t.elapsed_us = 20'(el);
      return t;
   endfunction

   // Random phase: mostly idle runs to hide, with movement bursts to show
   task automatic queue_random(input int count);
      int x, y, el;
      x = 0;
      y = 0;
      for (int i = 0; i < count; i++) begin
         case ($urandom_range(0, 9))
            0: el = $urandom_range(0, 20'hFFFFF);
            1: el = $urandom_range(100001, 1000000);
            default: el = $urandom_range(0, 100000);
         endcase
         if ($urandom_range(0, 9) < 3) begin
            x = $urandom_range(0, 65535);
            y = $urandom_range(0, 65535);
         end else if ($urandom_range(0, 9) < 2) begin
            x = x + $urandom_range(0, 6) - 3;
         end
         tick_queue.push_back(make_tick(x, y, $urandom_range(0, 3) != 0, el));
      end
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_ready = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      cycle_count = 0;
      error_count = 0;
      hold_sender = 1'b0;
      shadow_cfg = CFG_RESET;
      last_x = 0;
      last_y = 0;
      idle_us = 0;
      hidden = 1'b0;
      pos_fx = 0;
      pos_tgt = 0;
      pos_speed = 0;
      alpha_fx = 255 << 8;
      alpha_tgt = 255;
      alpha_speed = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed: field extremes, hide, show, elapsed times above the step cap
      write_register(REG_HIDE_DELAY, 32'd0);
      write_register(REG_POS_ACCEL, 32'd20000);
      write_register(REG_POS_SPEED, 32'd2048);
      tick_queue.push_back(make_tick(0, 0, 1'b0, 0));
      tick_queue.push_back(make_tick(0, 0, 1'b0, 1));
      tick_queue.push_back(make_tick(1, 0, 1'b1, 1000000));
      tick_queue.push_back(make_tick(1, 0, 1'b0, 20'hFFFFF));
      tick_queue.push_back(make_tick(1, 0, 1'b0, 100000));
      tick_queue.push_back(make_tick(-32768, 32767, 1'b1, 16000));
      tick_queue.push_back(make_tick(32767, -32768, 1'b0, 16000));
      tick_queue.push_back(make_tick(32767, -32768, 1'b0, 100001));
      for (int i = 0; i < 8; i++)
         tick_queue.push_back(make_tick(32767, -32768, 1'b0, 50000));
      // Pause the sender until all results are back
      while (tick_queue.size() > 0)
         @(posedge clock);
      hold_sender = 1'b1;
      tick_queue.push_back(make_tick(0, 0, 1'b1, 16000));
      for (int i = 0; i < 6; i++)
         tick_queue.push_back(make_tick(0, 0, 1'b1, 100000));
      while (req_valid || expected_results.size() > 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
      hold_sender = 1'b0;
      drain();

      // Extreme settings
      write_register(REG_HIDE_DELAY, 32'd65535);
      write_register(REG_MOVE_THR, 32'd255);
      write_register(REG_HIDDEN_POS, 32'd4095);
      write_register(REG_POS_ACCEL, 32'd65535);
      write_register(REG_POS_SPEED, 32'd65535);
      write_register(REG_ALPHA_ACCEL, 32'd65535);
      write_register(REG_ALPHA_SPEED, 32'd65535);
      queue_random(40);
      drain();

      for (int phase = 0; phase < 5; phase++) begin
         write_register(REG_HIDE_DELAY, $urandom_range(0, 300));
         write_register(REG_MOVE_THR, phase == 0 ? 0 : $urandom_range(0, 255));
         write_register(REG_HIDDEN_POS, $urandom_range(0, 4095));
         write_register(REG_POS_ACCEL, $urandom_range(0, 65535));
         write_register(REG_POS_SPEED, phase == 1 ? 0 : $urandom_range(0, 65535));
         write_register(REG_ALPHA_ACCEL, phase == 1 ? 0 : $urandom_range(0, 65535));
         write_register(REG_ALPHA_SPEED, $urandom_range(0, 65535));
         queue_random(80);
         drain();
      end

      if (error_count == 0) begin
         $display("auto_hide_fade_slide_engine_test: clean");
      end else begin
         $display("auto_hide_fade_slide_engine_test: errors");
      end
      $finish;
   end

endmodule
